// ===== rtl/mmrs_pkg.sv =====
// mmrs_pkg: shared types, constants and helpers of the memory map region splitter
// no dependencies; used by mmrs_ctrl, mmrs_out and the top level

package mmrs_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 64;
    localparam int KIND_W      = 8;
    localparam int TOTAL_W     = 5;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_MATCH = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_RANGE    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_CLEAR,
        S_READ,
        S_READ_WAIT,
        S_SCAN,
        S_SPLIT,
        S_SHIFT,
        S_PIECES,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [KIND_W-1:0] kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        mode_t      mode;
        logic [3:0] index;
        entry_t     region;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [TOTAL_W-1:0]   total;
        entry_t               entry;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [TOTAL_W-1:0] total_of(input logic [CNT_W-1:0] count);
        logic [31:0] wide;
        wide = 32'(count);
        return wide[TOTAL_W-1:0];
    endfunction

endpackage

// ===== rtl/mmrs_ram.sv =====
// mmrs_ram: generic single write port, single read port ram with registered read
// no dependencies

module mmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mmrs_ctrl.sv =====
// mmrs_ctrl: sequencer and datapath for append, insert, read and clear
// depends on mmrs_pkg; drives the table ram and hands results to mmrs_out

module mmrs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mmrs_pkg::item_t   s_item,
    output logic              res_valid,
    input  logic              res_ready,
    output mmrs_pkg::result_t res,
    output mmrs_pkg::ram_req_t ram_req,
    input  mmrs_pkg::entry_t  ram_rdata
);

    localparam logic [1:0] PIECE_LEAD  = 2'd0;
    localparam logic [1:0] PIECE_NEW   = 2'd1;
    localparam logic [1:0] PIECE_TRAIL = 2'd2;

    mmrs_pkg::state_t  state_reg, state_next;
    logic [mmrs_pkg::CNT_W-1:0] count_reg, count_next;
    mmrs_pkg::item_t   item_reg, item_next;
    logic [mmrs_pkg::ADDR_W:0]  end_reg, end_next;
    logic [mmrs_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [mmrs_pkg::IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [mmrs_pkg::IDX_W-1:0] found_idx_reg, found_idx_next;
    mmrs_pkg::entry_t  found_reg, found_next;
    logic [mmrs_pkg::ADDR_W:0]  found_end_reg, found_end_next;
    logic              lastdrop_reg, lastdrop_next;
    logic [1:0]        grow_reg, grow_next;
    logic [1:0]        piece_reg, piece_next;
    logic [mmrs_pkg::IDX_W-1:0] wr_idx_reg, wr_idx_next;
    mmrs_pkg::status_t res_status_reg, res_status_next;
    mmrs_pkg::entry_t  res_entry_reg, res_entry_next;

    logic [mmrs_pkg::ADDR_W:0]  scan_end;
    logic              hit;
    logic              scan_issue;
    logic              first_calc;
    logic              lastdrop_calc;
    logic [1:0]        grow_calc;
    logic [mmrs_pkg::CNT_W:0]   count_grown;
    logic              grown_over;
    logic              shift_issue;
    logic [mmrs_pkg::CNT_W-1:0] ptr_dec;
    logic              range_bad;
    logic              append_full;
    logic [1:0]        last_piece;
    mmrs_pkg::entry_t  piece_entry;

    // compare, split and piece arithmetic
    always_comb begin
        scan_end      = {1'b0, ram_rdata.base} + {1'b0, ram_rdata.length};
        hit           = pend_reg && (ram_rdata.base <= item_reg.region.base)
                        && (end_reg <= scan_end);
        scan_issue    = ptr_reg < count_reg;
        first_calc    = found_reg.base == item_reg.region.base;
        lastdrop_calc = found_end_reg == end_reg;
        grow_calc     = 2'd2 - {1'b0, first_calc} - {1'b0, lastdrop_calc};
        count_grown   = {1'b0, count_reg} + (mmrs_pkg::CNT_W + 1)'(grow_calc);
        grown_over    = 32'(count_grown) > mmrs_pkg::MAX_ENTRIES;
        shift_issue   = {1'b0, ptr_reg} > ((mmrs_pkg::CNT_W + 1)'(found_idx_reg)
                        + (mmrs_pkg::CNT_W + 1)'(1));
        ptr_dec       = ptr_reg - mmrs_pkg::CNT_W'(1);
        range_bad     = (32'(item_reg.index) >= 32'(count_reg))
                        || (32'(item_reg.index) >= mmrs_pkg::MAX_ENTRIES);
        append_full   = 32'(count_reg) >= mmrs_pkg::MAX_ENTRIES;
        last_piece    = PIECE_TRAIL - {1'b0, lastdrop_reg};
        unique case (piece_reg)
            PIECE_LEAD: begin
                piece_entry.base   = found_reg.base;
                piece_entry.length = item_reg.region.base - found_reg.base;
                piece_entry.kind   = found_reg.kind;
            end
            PIECE_TRAIL: begin
                piece_entry.base   = end_reg[mmrs_pkg::ADDR_W-1:0];
                piece_entry.length = found_end_reg[mmrs_pkg::ADDR_W-1:0]
                                     - end_reg[mmrs_pkg::ADDR_W-1:0];
                piece_entry.kind   = found_reg.kind;
            end
            default: begin
                piece_entry = item_reg.region;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mmrs_pkg::S_IDLE: begin
                if (s_valid) begin
                    unique case (s_item.mode)
                        mmrs_pkg::MODE_APPEND: state_next = mmrs_pkg::S_APPEND;
                        mmrs_pkg::MODE_INSERT: state_next = mmrs_pkg::S_SCAN;
                        mmrs_pkg::MODE_READ:   state_next = mmrs_pkg::S_READ;
                        mmrs_pkg::MODE_CLEAR:  state_next = mmrs_pkg::S_CLEAR;
                    endcase
                end
            end
            mmrs_pkg::S_APPEND:    state_next = mmrs_pkg::S_RESP;
            mmrs_pkg::S_CLEAR:     state_next = mmrs_pkg::S_RESP;
            mmrs_pkg::S_READ: begin
                state_next = range_bad ? mmrs_pkg::S_RESP : mmrs_pkg::S_READ_WAIT;
            end
            mmrs_pkg::S_READ_WAIT: state_next = mmrs_pkg::S_RESP;
            mmrs_pkg::S_SCAN: begin
                if (hit) begin
                    state_next = mmrs_pkg::S_SPLIT;
                end else if (!scan_issue && !pend_reg) begin
                    state_next = mmrs_pkg::S_RESP;
                end
            end
            mmrs_pkg::S_SPLIT: begin
                if (grown_over) begin
                    state_next = mmrs_pkg::S_RESP;
                end else if (grow_calc == 2'd0) begin
                    state_next = mmrs_pkg::S_PIECES;
                end else begin
                    state_next = mmrs_pkg::S_SHIFT;
                end
            end
            mmrs_pkg::S_SHIFT: begin
                if (!shift_issue && !pend_reg) begin
                    state_next = mmrs_pkg::S_PIECES;
                end
            end
            mmrs_pkg::S_PIECES: begin
                if (piece_reg == last_piece) begin
                    state_next = mmrs_pkg::S_RESP;
                end
            end
            mmrs_pkg::S_RESP: begin
                if (res_ready) begin
                    state_next = mmrs_pkg::S_IDLE;
                end
            end
            default: state_next = mmrs_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        count_next      = count_reg;
        item_next       = item_reg;
        end_next        = end_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_idx_next  = found_idx_reg;
        found_next      = found_reg;
        found_end_next  = found_end_reg;
        lastdrop_next   = lastdrop_reg;
        grow_next       = grow_reg;
        piece_next      = piece_reg;
        wr_idx_next     = wr_idx_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        ram_req         = '0;
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        unique case (state_reg)
            mmrs_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next       = s_item;
                    end_next        = {1'b0, s_item.region.base}
                                      + {1'b0, s_item.region.length};
                    ptr_next        = '0;
                    pend_next       = 1'b0;
                    res_status_next = mmrs_pkg::STAT_OK;
                    res_entry_next  = '0;
                end
            end
            mmrs_pkg::S_APPEND: begin
                if (append_full) begin
                    res_status_next = mmrs_pkg::STAT_FULL;
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = count_reg[mmrs_pkg::IDX_W-1:0];
                    ram_req.wdata = item_reg.region;
                    count_next    = count_reg + mmrs_pkg::CNT_W'(1);
                end
            end
            mmrs_pkg::S_CLEAR: begin
                count_next = '0;
            end
            mmrs_pkg::S_READ: begin
                ram_req.raddr = mmrs_pkg::IDX_W'(item_reg.index);
                if (range_bad) begin
                    res_status_next = mmrs_pkg::STAT_RANGE;
                end
            end
            mmrs_pkg::S_READ_WAIT: begin
                res_entry_next = ram_rdata;
            end
            mmrs_pkg::S_SCAN: begin
                pend_next = 1'b0;
                if (hit) begin
                    found_idx_next = pend_idx_reg;
                    found_next     = ram_rdata;
                    found_end_next = scan_end;
                end else begin
                    // one read per cycle; each entry is compared when its registered ram read data returns
                    ram_req.raddr = ptr_reg[mmrs_pkg::IDX_W-1:0];
                    pend_next     = scan_issue;
                    pend_idx_next = ptr_reg[mmrs_pkg::IDX_W-1:0];
                    ptr_next      = ptr_reg + mmrs_pkg::CNT_W'(scan_issue);
                    if (!scan_issue && !pend_reg) begin
                        res_status_next = mmrs_pkg::STAT_NO_MATCH;
                    end
                end
            end
            mmrs_pkg::S_SPLIT: begin
                lastdrop_next = lastdrop_calc;
                grow_next     = grow_calc;
                ptr_next      = count_reg;
                pend_next     = 1'b0;
                piece_next    = {1'b0, first_calc};
                wr_idx_next   = found_idx_reg;
                if (grown_over) begin
                    res_status_next = mmrs_pkg::STAT_FULL;
                end
            end
            mmrs_pkg::S_SHIFT: begin
                // move later entries up, highest first
                ram_req.raddr = ptr_dec[mmrs_pkg::IDX_W-1:0];
                if (pend_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pend_idx_reg + mmrs_pkg::IDX_W'(grow_reg);
                    ram_req.wdata = ram_rdata;
                end
                pend_next     = shift_issue;
                pend_idx_next = ptr_dec[mmrs_pkg::IDX_W-1:0];
                ptr_next      = shift_issue ? ptr_dec : ptr_reg;
            end
            mmrs_pkg::S_PIECES: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = wr_idx_reg;
                ram_req.wdata = piece_entry;
                piece_next    = piece_reg + 2'd1;
                wr_idx_next   = wr_idx_reg + mmrs_pkg::IDX_W'(1);
                if (piece_reg == last_piece) begin
                    count_next = count_reg + mmrs_pkg::CNT_W'(grow_reg);
                end
            end
            mmrs_pkg::S_RESP: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mmrs_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        end_reg        <= end_next;
        pend_idx_reg   <= pend_idx_next;
        found_idx_reg  <= found_idx_next;
        found_reg      <= found_next;
        found_end_reg  <= found_end_next;
        lastdrop_reg   <= lastdrop_next;
        grow_reg       <= grow_next;
        piece_reg      <= piece_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
    end

    assign res.status = res_status_reg;
    assign res.total  = mmrs_pkg::total_of(count_reg);
    assign res.entry  = res_entry_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= mmrs_pkg::MAX_ENTRIES)
        else $error("entry count above capacity");

    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmrs_pkg::S_SCAN) |-> !ram_req.we)
        else $error("table written during scan");

    a_shift_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmrs_pkg::S_SHIFT && ram_req.we && shift_issue)
        |-> (ram_req.waddr > ram_req.raddr))
        else $error("shift write overtakes pending read");

    a_piece_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmrs_pkg::S_PIECES)
        |-> (32'(wr_idx_reg) < mmrs_pkg::MAX_ENTRIES))
        else $error("piece written beyond capacity");

    a_count_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == mmrs_pkg::S_APPEND || state_reg == mmrs_pkg::S_CLEAR
          || state_reg == mmrs_pkg::S_PIECES) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside an update");
`endif

endmodule

// ===== rtl/mmrs_out.sv =====
// mmrs_out: result register between the sequencer and the m_ channel
// depends on mmrs_pkg

module mmrs_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  mmrs_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output mmrs_pkg::result_t m_res
);

    logic              valid_reg, valid_next;
    mmrs_pkg::result_t data_reg, data_next;

    always_comb begin
        res_ready  = !valid_reg || m_ready;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready) begin
            valid_next = res_valid;
            if (res_valid) begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

// ===== rtl/memory_map_region_splitter.sv =====
// memory_map_region_splitter: top level of the region table block
// depends on mmrs_pkg, mmrs_ram, mmrs_ctrl and mmrs_out
//
//   channel | dir | handshake          | fields
//   s_      | in  | s_valid / s_ready  | mode, entry_index, region_start, region_size,
//           |     |                    | region_kind
//   m_      | out | m_valid / m_ready  | status, entry_total, out_base, out_length,
//           |     |                    | out_kind
//
// append and clear pass through their own update state, read through S_READ and,
// for a valid index, S_READ_WAIT; insert runs scan, split, a shift of later entries when the table grows
// and up to three piece writes, with one table read per cycle through the single ram read port
// reset clears the entry count, the sequencer state and the output valid; table contents are not cleared
// a finished result waits in the output register while the next transaction is taken

module memory_map_region_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_entry_index,
    input  logic [63:0] s_region_start,
    input  logic [63:0] s_region_size,
    input  logic [7:0]  s_region_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_entry_total,
    output logic [63:0] m_out_base,
    output logic [63:0] m_out_length,
    output logic [7:0]  m_out_kind
);

    mmrs_pkg::item_t    s_item;
    mmrs_pkg::result_t  res;
    mmrs_pkg::result_t  m_res;
    mmrs_pkg::ram_req_t ram_req;
    mmrs_pkg::entry_t   ram_rdata;
    logic               res_valid;
    logic               res_ready;

    assign s_item.mode          = mmrs_pkg::mode_t'(s_mode);
    assign s_item.index         = s_entry_index;
    assign s_item.region.base   = s_region_start;
    assign s_item.region.length = s_region_size;
    assign s_item.region.kind   = s_region_kind;

    mmrs_ram #(
        .WIDTH (mmrs_pkg::ENTRY_W),
        .DEPTH (mmrs_pkg::MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    mmrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    mmrs_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status      = m_res.status;
    assign m_entry_total = m_res.total;
    assign m_out_base    = m_res.entry.base;
    assign m_out_length  = m_res.entry.length;
    assign m_out_kind    = m_res.entry.kind;

endmodule
